### design/bpsd_pkg.sv
// ----------------------------------------------------------------------------
// bpsd_pkg: shared types and constants for the BPS patch command decoder
// Item structs, phase encoding, op and status codes, varint limits.
// ----------------------------------------------------------------------------
package bpsd_pkg;

    localparam int OFFSET_BITS = 32;
    // Sizes are capped at 32 bits by the result fields
    localparam int LIMIT_BITS  = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
    // Varint accumulator: bound fits LIMIT_BITS+2, one more digit adds < 2^(LB+9)
    localparam int VAR_W       = LIMIT_BITS + 12;

    localparam logic [VAR_W-1:0] SIZE_LIMIT = VAR_W'((64'd1 << LIMIT_BITS) - 64'd1);
    localparam logic [VAR_W-1:0] VAR_BOUND  = VAR_W'((((64'd1 << LIMIT_BITS) - 64'd1) << 2)
                                                     + 64'd3);

    localparam logic [31:0] MIN_PATCH_LEN = 32'd19;
    localparam logic [31:0] CRC_BYTES     = 32'd12;
    localparam logic [31:0] MAGIC_LAST    = 32'd3;

    typedef enum logic [3:0] {
        PH_MAGIC   = 4'd0,
        PH_HSRC    = 4'd1,
        PH_HTGT    = 4'd2,
        PH_HMETA   = 4'd3,
        PH_SKIP    = 4'd4,
        PH_CMD     = 4'd5,
        PH_DELTA   = 4'd6,
        PH_LIT     = 4'd7,
        PH_TRAILER = 4'd8,
        PH_DONE    = 4'd9
    } phase_t;

    localparam logic [2:0] OP_SRC_READ = 3'd0;
    localparam logic [2:0] OP_LITERAL  = 3'd1;
    localparam logic [2:0] OP_SRC_COPY = 3'd2;
    localparam logic [2:0] OP_TGT_COPY = 3'd3;
    localparam logic [2:0] OP_DONE     = 3'd4;
    localparam logic [2:0] OP_ERROR    = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_MAGIC    = 3'd1;
    localparam logic [2:0] ST_SIZE     = 3'd2;
    localparam logic [2:0] ST_VARINT   = 3'd3;
    localparam logic [2:0] ST_OVERRUN  = 3'd4;
    localparam logic [2:0] ST_RANGE    = 3'd5;
    localparam logic [2:0] ST_TRAILING = 3'd6;

    localparam logic [1:0] ACT_SRC_READ = 2'd0;
    localparam logic [1:0] ACT_TGT_READ = 2'd1;
    localparam logic [1:0] ACT_SRC_COPY = 2'd2;

    localparam logic       CFG_SRC_BYTES    = 1'b0;
    localparam logic       CFG_PATCH_LENGTH = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] patch_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] target_offset;
        logic [31:0] span_length;
        logic [31:0] copy_offset;
        logic [7:0]  literal;
        logic [2:0]  status;
    } out_item_t;

    typedef struct packed {
        logic       done;
        logic       ovf;
        logic [VAR_W-1:0] value;
        logic [VAR_W-1:0] weight;
    } varint_res_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h42;
            2'd1:    b = 8'h50;
            2'd2:    b = 8'h53;
            default: b = 8'h31;
        endcase
        return b;
    endfunction

endpackage

### design/bpsd_varint.sv
// ----------------------------------------------------------------------------
// bpsd_varint: one byte of a BPS varint
// Adds the digit at the current weight and checks against the varint bound.
// ----------------------------------------------------------------------------
module bpsd_varint
    import bpsd_pkg::*;
(
    input  logic [VAR_W-1:0] value,
    input  logic [VAR_W-1:0] weight,
    input  logic [7:0]       data,
    output varint_res_t      res
);

    logic [VAR_W-1:0] digit_w;
    logic [VAR_W-1:0] v1;
    logic [VAR_W-1:0] w2;
    logic [VAR_W-1:0] v2;
    logic             ovf1;
    logic             ovf2;

    // weight is always a power of 128
    assign digit_w = VAR_W'({1'b0, data[6:0]}) * weight;
    assign v1      = value + digit_w;
    assign ovf1    = v1 > VAR_BOUND;
    assign w2      = weight << 7;
    assign v2      = v1 + w2;
    assign ovf2    = !data[7] && (v2 > VAR_BOUND);

    always_comb
    begin
        res.ovf    = ovf1 || ovf2;
        res.done   = !ovf1 && data[7];
        res.value  = data[7] ? v1 : v2;
        res.weight = data[7] ? weight : w2;
    end

endmodule

### design/bpsd_core.sv
// ----------------------------------------------------------------------------
// bpsd_core: decode state and single-pass step logic
// Updates patch decode state for one item and forms at most one result.
// ----------------------------------------------------------------------------
module bpsd_core
    import bpsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  in_item_t    item,
    input  logic [31:0] src_bytes,
    input  logic [31:0] patch_length,
    output logic        emit,
    output out_item_t   result
);

    phase_t           phase_reg, phase_next;
    logic [31:0]      bpos_reg, bpos_next;
    logic [VAR_W-1:0] vval_reg, vval_next;
    logic [VAR_W-1:0] vwt_reg, vwt_next;
    logic [VAR_W-1:0] pend_reg, pend_next;
    logic [31:0]      tsize_reg, tsize_next;
    logic [31:0]      left_reg, left_next;
    logic [31:0]      opos_reg, opos_next;
    logic [31:0]      sptr_reg, sptr_next;
    logic [31:0]      tptr_reg, tptr_next;
    logic             failed_reg, failed_next;
    logic [2:0]       fstat_reg, fstat_next;

    varint_res_t      vr;

    bpsd_varint u_varint (
        .value  (vval_reg),
        .weight (vwt_reg),
        .data   (item.patch_byte),
        .res    (vr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_MAGIC;
            bpos_reg   <= '0;
            vval_reg   <= '0;
            vwt_reg    <= VAR_W'(1);
            pend_reg   <= '0;
            tsize_reg  <= '0;
            left_reg   <= '0;
            opos_reg   <= '0;
            sptr_reg   <= '0;
            tptr_reg   <= '0;
            failed_reg <= 1'b0;
            fstat_reg  <= ST_OK;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            bpos_reg   <= bpos_next;
            vval_reg   <= vval_next;
            vwt_reg    <= vwt_next;
            pend_reg   <= pend_next;
            tsize_reg  <= tsize_next;
            left_reg   <= left_next;
            opos_reg   <= opos_next;
            sptr_reg   <= sptr_next;
            tptr_reg   <= tptr_next;
            failed_reg <= failed_next;
            fstat_reg  <= fstat_next;
        end
    end

    always_comb
    begin
        logic [31:0]        cmd_end;
        logic [31:0]        rest;
        logic               f0;
        logic [2:0]         fcode;
        logic               freq;
        logic [32:0]        len;
        logic [32:0]        cmd_len;
        logic [32:0]        room;
        logic signed [VAR_W+1:0] ptr;
        logic [31:0]        base;
        logic [7:0]         b;

        phase_next  = phase_reg;
        bpos_next   = bpos_reg;
        vval_next   = vval_reg;
        vwt_next    = vwt_reg;
        pend_next   = pend_reg;
        tsize_next  = tsize_reg;
        left_next   = left_reg;
        opos_next   = opos_reg;
        sptr_next   = sptr_reg;
        tptr_next   = tptr_reg;
        failed_next = failed_reg;
        fstat_next  = fstat_reg;
        emit        = 1'b0;
        result      = '0;
        f0          = 1'b0;
        freq        = 1'b0;
        fcode       = ST_OK;
        b           = item.patch_byte;
        cmd_end     = (patch_length >= MIN_PATCH_LEN) ? patch_length - CRC_BYTES : '0;
        rest        = cmd_end - bpos_reg - 32'd1;
        len         = 33'(pend_reg >> 2) + 33'd1;
        cmd_len     = 33'(vr.value >> 2) + 33'd1;
        room        = {1'b0, tsize_reg - opos_reg};
        ptr         = '0;
        base        = '0;

        if (item.kind)
        begin
            // restart: clear decode state, registers untouched
            phase_next  = PH_MAGIC;
            bpos_next   = '0;
            vval_next   = '0;
            vwt_next    = VAR_W'(1);
            pend_next   = '0;
            tsize_next  = '0;
            left_next   = '0;
            opos_next   = '0;
            sptr_next   = '0;
            tptr_next   = '0;
            failed_next = 1'b0;
            fstat_next  = ST_OK;
        end
        else if (phase_reg != PH_DONE && bpos_reg < patch_length)
        begin
            f0 = failed_reg;
            if (patch_length < MIN_PATCH_LEN && !failed_reg)
            begin
                f0         = 1'b1;
                fstat_next = ST_MAGIC;
            end

            if (!f0 && bpos_reg < cmd_end)
            begin
                case (phase_reg)
                    PH_MAGIC:
                    begin
                        if (b != magic_byte(bpos_reg[1:0]))
                        begin
                            freq = 1'b1; fcode = ST_MAGIC;
                        end
                        else if (bpos_reg >= MAGIC_LAST)
                            phase_next = PH_HSRC;
                    end
                    PH_HSRC, PH_HTGT, PH_HMETA:
                    begin
                        if (vr.ovf)
                        begin
                            freq = 1'b1; fcode = ST_VARINT;
                        end
                        else if (!vr.done)
                        begin
                            vval_next = vr.value;
                            vwt_next  = vr.weight;
                        end
                        else if (vr.value > SIZE_LIMIT)
                        begin
                            freq = 1'b1; fcode = ST_VARINT;
                        end
                        else if (phase_reg == PH_HSRC)
                        begin
                            if (vr.value != VAR_W'(src_bytes))
                            begin
                                freq = 1'b1; fcode = ST_SIZE;
                            end
                            else
                            begin
                                phase_next = PH_HTGT;
                                vval_next  = '0;
                                vwt_next   = VAR_W'(1);
                            end
                        end
                        else if (phase_reg == PH_HTGT)
                        begin
                            tsize_next = vr.value[31:0];
                            phase_next = PH_HMETA;
                            vval_next  = '0;
                            vwt_next   = VAR_W'(1);
                        end
                        else if (vr.value > VAR_W'(rest))
                        begin
                            freq = 1'b1; fcode = ST_OVERRUN;
                        end
                        else
                        begin
                            left_next  = vr.value[31:0];
                            phase_next = (vr.value[31:0] != '0) ? PH_SKIP : PH_CMD;
                            vval_next  = '0;
                            vwt_next   = VAR_W'(1);
                        end
                    end
                    PH_SKIP:
                    begin
                        left_next = left_reg - 32'd1;
                        if (left_next == '0)
                            phase_next = PH_CMD;
                    end
                    PH_LIT:
                    begin
                        emit                 = 1'b1;
                        result.op            = OP_LITERAL;
                        result.target_offset = opos_reg;
                        result.span_length   = 32'd1;
                        result.literal       = b;
                        opos_next            = opos_reg + 32'd1;
                        left_next            = left_reg - 32'd1;
                        if (left_next == '0)
                            phase_next = PH_CMD;
                    end
                    PH_CMD:
                    begin
                        if (opos_reg >= tsize_reg)
                        begin
                            freq = 1'b1; fcode = ST_TRAILING;
                        end
                        else if (vr.ovf)
                        begin
                            freq = 1'b1; fcode = ST_VARINT;
                        end
                        else if (!vr.done)
                        begin
                            vval_next = vr.value;
                            vwt_next  = vr.weight;
                        end
                        else
                        begin
                            pend_next = vr.value;
                            vval_next = '0;
                            vwt_next  = VAR_W'(1);
                            if (cmd_len > room)
                            begin
                                freq = 1'b1; fcode = ST_OVERRUN;
                            end
                            else if (vr.value[1:0] == ACT_SRC_READ)
                            begin
                                if (({1'b0, opos_reg} + cmd_len) > {1'b0, src_bytes})
                                begin
                                    freq = 1'b1; fcode = ST_RANGE;
                                end
                                else
                                begin
                                    emit                 = 1'b1;
                                    result.op            = OP_SRC_READ;
                                    result.target_offset = opos_reg;
                                    result.span_length   = cmd_len[31:0];
                                    result.copy_offset   = opos_reg;
                                    opos_next            = opos_reg + cmd_len[31:0];
                                end
                            end
                            else if (vr.value[1:0] == ACT_TGT_READ)
                            begin
                                if (cmd_len > {1'b0, rest})
                                begin
                                    freq = 1'b1; fcode = ST_OVERRUN;
                                end
                                else
                                begin
                                    left_next  = cmd_len[31:0];
                                    phase_next = PH_LIT;
                                end
                            end
                            else
                                phase_next = PH_DELTA;
                        end
                    end
                    PH_DELTA:
                    begin
                        if (vr.ovf)
                        begin
                            freq = 1'b1; fcode = ST_VARINT;
                        end
                        else if (!vr.done)
                        begin
                            vval_next = vr.value;
                            vwt_next  = vr.weight;
                        end
                        else
                        begin
                            base = (pend_reg[1:0] == ACT_SRC_COPY) ? sptr_reg : tptr_reg;
                            // zigzag: low bit is the sign, the rest the magnitude
                            if (vr.value[0])
                                ptr = $signed({2'b00, VAR_W'(base)})
                                      - $signed({3'b000, vr.value[VAR_W-1:1]});
                            else
                                ptr = $signed({2'b00, VAR_W'(base)})
                                      + $signed({3'b000, vr.value[VAR_W-1:1]});
                            vval_next  = '0;
                            vwt_next   = VAR_W'(1);
                            phase_next = PH_CMD;
                            if (ptr < 0)
                            begin
                                freq = 1'b1; fcode = ST_RANGE;
                            end
                            else if (pend_reg[1:0] == ACT_SRC_COPY &&
                                     (ptr > $signed({2'b00, VAR_W'(src_bytes)}) ||
                                      len > ({1'b0, src_bytes} - 33'(ptr))))
                            begin
                                freq = 1'b1; fcode = ST_RANGE;
                            end
                            else if (pend_reg[1:0] != ACT_SRC_COPY &&
                                     ptr >= $signed({2'b00, VAR_W'(opos_reg)}))
                            begin
                                freq = 1'b1; fcode = ST_RANGE;
                            end
                            else
                            begin
                                emit                 = 1'b1;
                                result.op            = (pend_reg[1:0] == ACT_SRC_COPY) ?
                                                       OP_SRC_COPY : OP_TGT_COPY;
                                result.target_offset = opos_reg;
                                result.span_length   = len[31:0];
                                result.copy_offset   = ptr[31:0];
                                opos_next            = opos_reg + len[31:0];
                                if (pend_reg[1:0] == ACT_SRC_COPY)
                                    sptr_next = ptr[31:0] + len[31:0];
                                else
                                    tptr_next = ptr[31:0] + len[31:0];
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (!f0 && phase_reg != PH_TRAILER)
            begin
                // CRC area reached: command stream must be complete
                if (phase_reg != PH_CMD || opos_reg != tsize_reg ||
                    vval_reg != '0 || vwt_reg != VAR_W'(1))
                begin
                    freq = 1'b1; fcode = ST_TRAILING;
                end
                phase_next = PH_TRAILER;
            end

            if (freq && !f0)
            begin
                fstat_next = fcode;
            end
            failed_next = f0 || freq;

            if (bpos_reg == patch_length - 32'd1)
            begin
                emit   = 1'b1;
                result = '0;
                if (failed_next)
                begin
                    result.op     = OP_ERROR;
                    result.status = fstat_next;
                end
                else
                begin
                    result.op            = OP_DONE;
                    result.target_offset = opos_next;
                end
                phase_next = PH_DONE;
            end
            bpos_next = bpos_reg + 32'd1;
        end
    end

endmodule

### design/bps_patch_command_decoder.sv
// ----------------------------------------------------------------------------
// bps_patch_command_decoder: BPS patch structure decoder
// Pipeline: an item is registered on entry and decoded in one pass into the
//   output register; out_valid rises when that register is loaded.
// Throughput: one patch byte per cycle while results are taken; the input and
//   output registers let a new item enter while a result waits to be taken.
// Reset (rst_n, async, active low) clears decode state, pipeline valids and
//   both configuration registers. A restart item clears decode state only.
// ----------------------------------------------------------------------------
module bps_patch_command_decoder
    import bpsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic [31:0] src_bytes_reg;
    logic [31:0] patch_length_reg;

    // input stage
    logic        in_v_reg;
    in_item_t    in_reg;

    // result stage
    logic        out_v_reg, out_v_next;
    out_item_t   out_reg;

    logic        advance;
    logic        emit;
    out_item_t   result;

    // decode when the result stage is free or draining this cycle
    assign advance  = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready = !in_v_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_bytes_reg    <= '0;
            patch_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_BYTES:    src_bytes_reg    <= cfg_data;
                CFG_PATCH_LENGTH: patch_length_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_v_reg <= 1'b0;
        else if (in_ready)
            in_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_reg <= in_data;
    end

    bpsd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .item         (in_reg),
        .src_bytes    (src_bytes_reg),
        .patch_length (patch_length_reg),
        .emit         (emit),
        .result       (result)
    );

    always_comb
    begin
        if (advance && emit)
            out_v_next = 1'b1;
        else if (out_ready)
            out_v_next = 1'b0;
        else
            out_v_next = out_v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else
            out_v_reg <= out_v_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_reg <= result;
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    // a restart item never produces a result
    a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_reg.kind) |-> !emit)
        else $error("restart item produced a result");

    // the decoder only steps when the result register can take its output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (!out_v_reg || out_ready))
        else $error("result register overwritten");

    // status is nonzero only on an error result
    a_status_err: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.op != OP_ERROR) |-> (out_data.status == ST_OK))
        else $error("status set on non-error result");

    // error results always carry a code
    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.op == OP_ERROR) |-> (out_data.status != ST_OK))
        else $error("error result without a code");

endmodule
